FILE: rtl/core/csdc_pkg.sv
// Shared types, constants and the tempo ratio table of the clock synced
// delay control unit. No dependencies; imported by every module of the core.
package csdc_pkg;

    // Depth of the period store; legal range 2 to 16.
    localparam int CLOCK_TICKS = 4;
    localparam int CT_W        = (CLOCK_TICKS > 1) ? $clog2(CLOCK_TICKS) : 1;
    localparam int EDGE_W      = 5;
    localparam int TOT_W       = 32 + CT_W;

    localparam int FB_W    = 13;
    localparam int CLK_W   = 12;
    localparam int TIME_W  = 32;
    localparam int SMOOTH_W = 24;
    localparam int DIFF_W  = 25;
    localparam int DELAY_W = 24;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 40;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FB   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_THR = 2'd1;

    localparam logic [FB_W-1:0]  MAX_FB_RESET   = 13'd3891;
    localparam logic [CLK_W-1:0] GATE_THR_RESET = 12'd2048;
    localparam logic [FB_W-1:0]  UNITY          = 13'd4096;

    localparam logic signed [DIFF_W-1:0] DEAD_BAND   = 25'sd83886;
    localparam logic signed [13:0]       SMOOTH_COEF = 14'sd4194;
    localparam int SMOOTH_SH = 22;

    localparam logic [DELAY_W-1:0] DELAY_MAX = 24'hFFFFFF;

    // Shared multiplier: signed operands, registered product.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 14;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Shared divider: unsigned dividend, small divisor.
    localparam int DIV_W     = 45;
    localparam int DEN_W     = 6;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam int FACTOR_W = 13;

    typedef struct packed {
        logic [FACTOR_W-1:0] factor;   // 48 * numerator
        logic [DEN_W-1:0]    den;
    } t_ratio;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic t_ratio ratio_of(input logic [FB_W-1:0] pot);
        t_ratio r;
        if (pot == 13'd0) begin
            r = '{factor: 13'd48, den: 6'd8};
        end else if (pot <= 13'd409) begin
            r = '{factor: 13'd48, den: 6'd4};
        end else if (pot <= 13'd819) begin
            r = '{factor: 13'd48, den: 6'd3};
        end else if (pot <= 13'd1228) begin
            r = '{factor: 13'd48, den: 6'd2};
        end else if (pot <= 13'd1638) begin
            r = '{factor: 13'd96, den: 6'd3};
        end else if (pot <= 13'd2048) begin
            r = '{factor: 13'd48, den: 6'd1};
        end else if (pot <= 13'd2457) begin
            r = '{factor: 13'd96, den: 6'd1};
        end else if (pot <= 13'd2867) begin
            r = '{factor: 13'd4800, den: 6'd33};
        end else if (pot <= 13'd3276) begin
            r = '{factor: 13'd192, den: 6'd1};
        end else if (pot <= 13'd3686) begin
            r = '{factor: 13'd240, den: 6'd1};
        end else begin
            r = '{factor: 13'd384, den: 6'd1};
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/csdc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on csdc_pkg for operand widths.
module csdc_mul
    import csdc_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

FILE: rtl/core/csdc_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on csdc_pkg for widths and the request/status structs.
module csdc_div
    import csdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output t_div_stat        o_stat,
    output logic [DIV_W-1:0] o_quo
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [DIV_W-1:0]     r_quo;

    logic [DEN_W:0] n_trial;
    logic           n_fit;

    always_comb begin
        n_trial = {r_rem, r_quo[DIV_W-1]};
        n_fit   = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend out at the top, quotient in at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], n_fit};
            r_rem <= n_fit ? DEN_W'(n_trial - {1'b0, r_den}) : n_trial[DEN_W-1:0];
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quo  = r_quo;

endmodule

FILE: rtl/core/clock_synced_delay_control_unit.sv
// Top level of the clock synced delay control unit: sequencer, state and I/O.
// Depends on csdc_pkg, csdc_mul and csdc_div.
//
// Usage:
//   One control update enters per slave-side transaction (i_s_*). It carries
//   both pots, the clock CV, the feedback CV and a millisecond time stamp.
//   Each update yields exactly one master-side transaction (o_m_*) with the
//   delay in samples, the feedback gain and, in tuser, the tempo update flag.
//   The configuration channel (i_cfg_*) writes max_feedback (index 0) and
//   gate_threshold (index 1); it is always ready. The user is to use it only
//   while idle; the block itself does not enforce this.
// Sequence:
//   An update passes the feedback states S_FB1 to S_FB4, the edge state
//   S_EDGE, S_DLY1 and S_DLY2 to form the delay product and start the divide,
//   S_DLYW on the shared 45-step divider and S_OUT to load the output. An
//   update that closes a run of CLOCK_TICKS edges adds S_SUM over the store
//   and S_AVG. Input is ready only in S_IDLE. Only one update is in work.
// Reset and stall:
//   Synchronous active-low reset clears the period store, the edge state,
//   the smoother and the average, and loads the register defaults.
//   A result waits in the output register while the receiver stalls; the
//   next update is accepted meanwhile and holds in its final step until
//   the output register frees up.
module clock_synced_delay_control_unit
    import csdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [12:0] feedback_pot, [25:13] divisor_pot, [37:26] clock_cv,
    // [50:38] feedback_cv, [82:51] now_ms, [87:83] zero
    input  logic [S_TDATA_W-1:0]  i_s_tdata,

    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [23:0] delay_samples, [36:24] feedback_gain, [39:37] zero
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // [0] tempo_updated
    output logic [0:0]            o_m_tuser,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_FB1, S_FB2, S_FB3, S_FB4, S_EDGE, S_SUM,
        S_AVG, S_DLY1, S_DLY2, S_DLYW, S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [FB_W-1:0]  r_max_fb;
    logic [CLK_W-1:0] r_gate_thr;

    // Latched input transaction
    logic [FB_W-1:0]        r_fb_pot;
    logic [FB_W-1:0]        r_div_pot;
    logic [CLK_W-1:0]       r_clk_cv;
    logic signed [FB_W-1:0] r_fb_cv;
    logic [TIME_W-1:0]      r_now;

    // Block state
    logic                       r_gate_was;
    logic [EDGE_W-1:0]          r_edge_cnt;
    logic [TIME_W-1:0]          r_last_ms;
    logic                       r_last_valid;
    logic [TIME_W-1:0]          r_store [CLOCK_TICKS];
    logic [TIME_W-1:0]          r_avg;
    logic signed [SMOOTH_W-1:0] r_smooth;

    // Per-update working registers
    logic                r_band;
    logic [FB_W-1:0]     r_gain;
    logic                r_upd;
    logic [CT_W-1:0]     r_sum_idx;
    logic [TOT_W-1:0]    r_total;
    logic [DELAY_W-1:0]  r_delay;

    // Output register
    logic                r_m_valid;
    logic [DELAY_W-1:0]  r_m_delay;
    logic [FB_W-1:0]     r_m_gain;
    logic                r_m_upd;

    // Shared units
    logic signed [MUL_A_W-1:0] n_mul_a;
    logic signed [MUL_B_W-1:0] n_mul_b;
    logic signed [MUL_P_W-1:0] w_mul_p;
    t_div_req                  n_div_req;
    t_div_stat                 w_div_stat;
    logic [DIV_W-1:0]          w_div_quo;

    // Combinational helpers
    logic signed [DIFF_W-1:0]   n_diff;
    logic signed [MUL_P_W-1:0]  n_step;
    logic signed [DIFF_W-1:0]   n_smooth_ext;
    logic signed [SMOOTH_W-1:0] n_smooth_sh;
    logic signed [14:0]         n_fb_sum;
    logic [FB_W-1:0]            n_fb_clamp;
    logic [FB_W-1:0]            n_mf;
    t_ratio                     n_ratio;
    logic                       n_gate;
    logic [EDGE_W-1:0]          n_cnt_inc;
    logic [CT_W-1:0]            n_wr_idx;
    logic                       n_wr_en;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);

    always_comb begin
        // Distance of the smoother from the scaled CV, both as Q0.23
        n_diff = $signed({r_fb_cv, 11'd0}) - DIFF_W'(r_smooth);
        // Floor of diff * coef / 2^22 comes out of an arithmetic shift
        n_step = w_mul_p >>> SMOOTH_SH;
        n_smooth_ext = $signed({r_smooth[SMOOTH_W-1], r_smooth})
                     + $signed(n_step[DIFF_W-1:0]);

        n_smooth_sh = r_smooth >>> 11;
        n_fb_sum    = $signed(n_smooth_sh[14:0]) + $signed({2'b00, r_fb_pot});
        if (n_fb_sum < 15'sd0) begin
            n_fb_clamp = '0;
        end else if (n_fb_sum > 15'sd4096) begin
            n_fb_clamp = UNITY;
        end else begin
            n_fb_clamp = n_fb_sum[FB_W-1:0];
        end
        n_mf = (r_max_fb > UNITY) ? UNITY : r_max_fb;

        n_ratio = ratio_of(r_div_pot);

        n_gate    = (r_clk_cv >= r_gate_thr);
        n_cnt_inc = r_edge_cnt + 1'b1;
        n_wr_idx  = (n_cnt_inc == EDGE_W'(CLOCK_TICKS)) ? '0 : n_cnt_inc[CT_W-1:0];
        n_wr_en   = (r_state == S_EDGE) && n_gate && !r_gate_was && r_last_valid;
    end

    // Operand selection for the shared multiplier and divider
    always_comb begin
        n_mul_a   = '0;
        n_mul_b   = '0;
        n_div_req = '{start: 1'b0, dividend: '0, divisor: '0};
        unique case (r_state)
            S_FB1: begin
                n_mul_a = MUL_A_W'(n_diff);
                n_mul_b = SMOOTH_COEF;
            end
            S_FB3: begin
                n_mul_a = $signed({20'd0, n_fb_clamp});
                n_mul_b = $signed({1'b0, n_mf});
            end
            S_DLY1: begin
                n_mul_a = $signed({1'b0, r_avg});
                n_mul_b = $signed({1'b0, n_ratio.factor});
            end
            S_DLY2: begin
                n_div_req = '{start: 1'b1, dividend: w_mul_p[DIV_W-1:0],
                              divisor: n_ratio.den};
            end
            default: begin
            end
        endcase
    end

    csdc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (n_mul_a),
        .i_b   (n_mul_b),
        .o_p   (w_mul_p)
    );

    csdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_stat  (w_div_stat),
        .o_quo   (w_div_quo)
    );

    // Period store: cleared at reset, written on a timed rising edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CLOCK_TICKS; i++) begin
                r_store[i] <= '0;
            end
        end else if (n_wr_en) begin
            r_store[n_wr_idx] <= r_now - r_last_ms;
        end
    end

    // Latch the input transaction
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_fb_pot  <= i_s_tdata[12:0];
            r_div_pot <= i_s_tdata[25:13];
            r_clk_cv  <= i_s_tdata[37:26];
            r_fb_cv   <= $signed(i_s_tdata[50:38]);
            r_now     <= i_s_tdata[82:51];
        end
    end

    // Sequencer, block state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_max_fb     <= MAX_FB_RESET;
            r_gate_thr   <= GATE_THR_RESET;
            r_gate_was   <= 1'b0;
            r_edge_cnt   <= '0;
            r_last_ms    <= '0;
            r_last_valid <= 1'b0;
            r_avg        <= '0;
            r_smooth     <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MAX_FB:   r_max_fb   <= i_cfg_data;
                    REG_GATE_THR: r_gate_thr <= i_cfg_data[CLK_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Load a finished result when the output register is free,
            // otherwise drop the result once the receiver takes it
            if ((r_state == S_OUT) && (!r_m_valid || i_m_tready)) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_FB1;
                    end
                end
                S_FB1: begin
                    r_band  <= (n_diff > DEAD_BAND) || (n_diff < -DEAD_BAND);
                    r_state <= S_FB2;
                end
                S_FB2: begin
                    // Move the smoother only outside the dead band
                    if (r_band) begin
                        r_smooth <= n_smooth_ext[SMOOTH_W-1:0];
                    end
                    r_state <= S_FB3;
                end
                S_FB3: begin
                    r_state <= S_FB4;
                end
                S_FB4: begin
                    r_gain  <= w_mul_p[24:12];
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    if (n_gate && !r_gate_was) begin
                        if (n_cnt_inc >= EDGE_W'(CLOCK_TICKS)) begin
                            r_edge_cnt <= '0;
                        end else begin
                            r_edge_cnt <= n_cnt_inc;
                        end
                        r_last_ms    <= r_now;
                        r_last_valid <= 1'b1;
                    end
                    // A full run of timed edges closes with a new average
                    if (n_gate && !r_gate_was && r_last_valid
                            && (n_cnt_inc >= EDGE_W'(CLOCK_TICKS))) begin
                        r_upd     <= 1'b1;
                        r_sum_idx <= '0;
                        r_total   <= '0;
                        r_state   <= S_SUM;
                    end else begin
                        r_upd   <= 1'b0;
                        r_state <= S_DLY1;
                    end
                    r_gate_was <= n_gate;
                end
                S_SUM: begin
                    r_total   <= r_total + TOT_W'(r_store[r_sum_idx]);
                    r_sum_idx <= r_sum_idx + 1'b1;
                    if (r_sum_idx == CT_W'(CLOCK_TICKS - 1)) begin
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    r_avg   <= TIME_W'(r_total / TOT_W'(CLOCK_TICKS));
                    r_state <= S_DLY1;
                end
                S_DLY1: begin
                    r_state <= S_DLY2;
                end
                S_DLY2: begin
                    r_state <= S_DLYW;
                end
                S_DLYW: begin
                    if (w_div_stat.done) begin
                        // Saturate the delay at the field maximum
                        if (w_div_quo > DIV_W'(DELAY_MAX)) begin
                            r_delay <= DELAY_MAX;
                        end else begin
                            r_delay <= w_div_quo[DELAY_W-1:0];
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (!r_m_valid || i_m_tready) begin
                        r_m_delay <= r_delay;
                        r_m_gain  <= r_gain;
                        r_m_upd   <= r_upd;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {3'd0, r_m_gain, r_m_delay};
    assign o_m_tuser  = r_m_upd;

`ifndef SYNTHESIS
    // Edge count always restarts before reaching the store depth
    a_edge_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_cnt < EDGE_W'(CLOCK_TICKS))
        else $error("edge count reached store depth");

    // The shared divider is never restarted while it iterates
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(n_div_req.start && w_div_stat.busy))
        else $error("divider started while busy");

    // An accepted update blocks further input until it completes
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second update accepted while one is in work");
`endif

endmodule
